FILE: rtl/tcw_pkg.sv
// shared constants, types and codes for the text console writer
// no dependencies; every other file in rtl/ refers to this package by scoped names

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int SCREENS = 4;

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int SCR_W      = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int OFF_W      = CELL_W;
  localparam int MEM_AW     = SCR_W + CELL_W;
  localparam int MEM_DEPTH  = 2 ** MEM_AW;
  localparam int SCROLL_LEN = (ROWS - 1) * COLUMNS;

  // command queue between decode and execution, power of two deep
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] BLANK_CELL   = 16'h0F20;
  localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;

  // request codes on the input tuser
  localparam logic [2:0] REQ_CURSOR_CHAR = 3'd0;
  localparam logic [2:0] REQ_POS_CHAR    = 3'd1;
  localparam logic [2:0] REQ_CLEAR       = 3'd2;
  localparam logic [2:0] REQ_SWITCH      = 3'd3;
  localparam logic [2:0] REQ_READ        = 3'd4;

  // decoded commands
  typedef enum logic [2:0] {
    CMD_PUT_CHAR,
    CMD_NEWLINE,
    CMD_PUT_AT,
    CMD_CLEAR,
    CMD_SWITCH,
    CMD_READ,
    CMD_IGNORE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [7:0]         chr;
    logic [7:0]         attr;
    logic [CELL_W-1:0]  pos;
    logic [SCR_W-1:0]   target;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        data;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [OFF_W-1:0]   off;
    logic [SCR_W-1:0]   scr;
    logic               status;
  } result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EMIT,
    ST_SCROLL,
    ST_FILL
  } state_t;

endpackage

FILE: rtl/tcw_front.sv
// request decoder: range checks and classification of incoming requests
// depends on tcw_pkg

module tcw_front (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // char_code, attribute, cell_position, screen_number
  input  logic [2:0]         s_tuser,   // req_type
  input  logic               q_full,
  input  logic               init_done,
  output logic               push,
  output tcw_pkg::cmd_t      cmd
);

  logic [7:0]  chr;
  logic [7:0]  attr;
  logic [10:0] pos;
  logic [2:0]  scr;
  logic        pos_ok;
  logic        target_ok;

  assign chr  = s_tdata[7:0];
  assign attr = s_tdata[15:8];
  assign pos  = s_tdata[26:16];
  assign scr  = s_tdata[29:27];

  assign pos_ok    = 32'(pos) < 32'(tcw_pkg::CELLS);
  assign target_ok = 32'(scr) < 32'(tcw_pkg::SCREENS);

  assign s_tready = init_done && !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    cmd.chr    = chr;
    cmd.attr   = attr;
    cmd.pos    = tcw_pkg::CELL_W'(pos);
    cmd.target = tcw_pkg::SCR_W'(scr);
    unique case (s_tuser)
      tcw_pkg::REQ_CURSOR_CHAR: begin
        cmd.op = (chr == tcw_pkg::NEWLINE_CHAR) ? tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_PUT_CHAR;
      end
      tcw_pkg::REQ_POS_CHAR: cmd.op = pos_ok ? tcw_pkg::CMD_PUT_AT : tcw_pkg::CMD_IGNORE;
      tcw_pkg::REQ_CLEAR:    cmd.op = tcw_pkg::CMD_CLEAR;
      tcw_pkg::REQ_SWITCH:   cmd.op = target_ok ? tcw_pkg::CMD_SWITCH : tcw_pkg::CMD_IGNORE;
      tcw_pkg::REQ_READ:     cmd.op = pos_ok ? tcw_pkg::CMD_READ : tcw_pkg::CMD_IGNORE;
      default:               cmd.op = tcw_pkg::CMD_IGNORE;
    endcase
  end

endmodule

FILE: rtl/tcw_queue.sv
// short command queue decoupling the decoder from the execution sequencer
// depends on tcw_pkg

module tcw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcw_pkg::cmd_t  wr_cmd,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output tcw_pkg::cmd_t  head
);

  tcw_pkg::cmd_t slots [tcw_pkg::QUEUE_DEPTH];

  logic [tcw_pkg::QPTR_W-1:0] wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0] rd_ptr;
  logic [tcw_pkg::QPTR_W:0]   count;
  logic [tcw_pkg::QPTR_W:0]   count_next;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  assign full  = count == (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

endmodule

FILE: rtl/tcw_back.sv
// execution sequencer: screen cell memory, per-screen cursors, scroll and clear sweeps
// depends on tcw_pkg

module tcw_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  tcw_pkg::cmd_t     head,
  input  logic              slot_free,
  output logic              pop,
  output logic              init_done,
  output logic              emit,
  output tcw_pkg::result_t  result
);

  logic [15:0] cells [tcw_pkg::MEM_DEPTH];
  logic [15:0] rd_q;

  logic [tcw_pkg::COL_W-1:0] col_mem [tcw_pkg::SCREENS];
  logic [tcw_pkg::ROW_W-1:0] row_mem [tcw_pkg::SCREENS];

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;

  logic [tcw_pkg::MEM_AW-1:0] sweep;
  logic [tcw_pkg::MEM_AW-1:0] sweep_next;
  logic [tcw_pkg::CELL_W-1:0] sweep_cell;
  logic [tcw_pkg::SCR_W-1:0]  cur_scr;

  logic [tcw_pkg::COL_W-1:0]  res_col;
  logic [tcw_pkg::ROW_W-1:0]  res_row;
  logic                       res_status;
  logic                       res_read;

  logic                       start;
  logic                       moves_cursor;
  logic [tcw_pkg::SCR_W-1:0]  sel;
  logic [tcw_pkg::COL_W-1:0]  c_col;
  logic [tcw_pkg::ROW_W-1:0]  c_row;
  logic [tcw_pkg::CELL_W-1:0] cursor_cell;
  logic [tcw_pkg::COL_W:0]    col_inc;
  logic [tcw_pkg::ROW_W:0]    row_inc;
  logic [tcw_pkg::COL_W-1:0]  new_col;
  logic [tcw_pkg::ROW_W-1:0]  new_row;
  logic [tcw_pkg::SCR_W-1:0]  new_scr;
  logic                       new_status;
  logic                       go_scroll;

  logic                       mem_we;
  logic [tcw_pkg::MEM_AW-1:0] mem_wa;
  logic [15:0]                mem_wd;
  logic [tcw_pkg::MEM_AW-1:0] mem_ra;

  assign start        = (state == tcw_pkg::ST_IDLE) && q_valid && slot_free;
  assign pop          = start;
  assign init_done    = state != tcw_pkg::ST_INIT;
  assign sweep_cell   = sweep[tcw_pkg::CELL_W-1:0];
  assign moves_cursor = (head.op == tcw_pkg::CMD_PUT_CHAR) || (head.op == tcw_pkg::CMD_NEWLINE)
                        || (head.op == tcw_pkg::CMD_CLEAR);

  // a switch looks at the target's cursor, everything else at the active one
  assign sel   = (head.op == tcw_pkg::CMD_SWITCH) ? head.target : cur_scr;
  assign c_col = col_mem[sel];
  assign c_row = row_mem[sel];
  assign cursor_cell = tcw_pkg::CELL_W'(32'(c_row) * tcw_pkg::COLUMNS + 32'(c_col));

  // cursor update and status of the command at the queue head
  always_comb begin
    new_col    = c_col;
    new_row    = c_row;
    new_scr    = cur_scr;
    new_status = 1'b0;
    go_scroll  = 1'b0;
    col_inc    = '0;
    row_inc    = '0;
    unique case (head.op)
      tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CMD_NEWLINE: begin
        if (head.op == tcw_pkg::CMD_NEWLINE) begin
          col_inc = '0;
          row_inc = {1'b0, c_row} + 1'b1;
        end else begin
          col_inc = {1'b0, c_col} + 1'b1;
          row_inc = {1'b0, c_row};
        end
        if (col_inc >= (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS)) begin
          col_inc = '0;
          row_inc = row_inc + 1'b1;
        end
        new_col = col_inc[tcw_pkg::COL_W-1:0];
        if (row_inc >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)) begin
          go_scroll = 1'b1;
          new_row   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
        end else begin
          new_row = row_inc[tcw_pkg::ROW_W-1:0];
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        new_col = '0;
        new_row = '0;
      end
      tcw_pkg::CMD_SWITCH: begin
        if (head.target == cur_scr) new_status = 1'b1;
        else                        new_scr    = head.target;
      end
      tcw_pkg::CMD_PUT_AT, tcw_pkg::CMD_READ: begin
        new_status = 1'b0;
      end
      tcw_pkg::CMD_IGNORE: new_status = 1'b1;
      default:             new_status = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        if (sweep == tcw_pkg::MEM_AW'(tcw_pkg::MEM_DEPTH - 1)) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          if (head.op == tcw_pkg::CMD_CLEAR) state_next = tcw_pkg::ST_FILL;
          else if (go_scroll)                state_next = tcw_pkg::ST_SCROLL;
          else                               state_next = tcw_pkg::ST_EMIT;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (sweep == tcw_pkg::MEM_AW'(tcw_pkg::SCROLL_LEN)) state_next = tcw_pkg::ST_FILL;
      end
      tcw_pkg::ST_FILL: begin
        if (sweep == tcw_pkg::MEM_AW'(tcw_pkg::CELLS - 1)) state_next = tcw_pkg::ST_EMIT;
      end
      tcw_pkg::ST_EMIT: state_next = tcw_pkg::ST_IDLE;
      default:          state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // memory ports, sweep counter and result strobe
  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = {cur_scr, head.pos};
    mem_wd     = tcw_pkg::BLANK_CELL;
    mem_ra     = {cur_scr, head.pos};
    sweep_next = sweep;
    emit       = 1'b0;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        mem_we     = 1'b1;
        mem_wa     = sweep;
        sweep_next = sweep + 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        sweep_next = '0;
        if (start && head.op == tcw_pkg::CMD_PUT_CHAR) begin
          mem_we = 1'b1;
          mem_wa = {cur_scr, cursor_cell};
          mem_wd = {head.attr, head.chr};
        end else if (start && head.op == tcw_pkg::CMD_PUT_AT) begin
          mem_we = 1'b1;
          mem_wd = {head.attr, head.chr};
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // read one row below, write it back in the next cycle
        mem_ra = {cur_scr, tcw_pkg::CELL_W'(32'(sweep_cell) + tcw_pkg::COLUMNS)};
        mem_we = sweep != '0;
        mem_wa = {cur_scr, sweep_cell - 1'b1};
        mem_wd = rd_q;
        if (sweep != tcw_pkg::MEM_AW'(tcw_pkg::SCROLL_LEN)) sweep_next = sweep + 1'b1;
      end
      tcw_pkg::ST_FILL: begin
        mem_we     = 1'b1;
        mem_wa     = {cur_scr, sweep_cell};
        sweep_next = sweep + 1'b1;
      end
      tcw_pkg::ST_EMIT: emit = 1'b1;
      default:          emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tcw_pkg::ST_INIT;
      sweep   <= '0;
      cur_scr <= '0;
      for (int s = 0; s < tcw_pkg::SCREENS; s++) begin
        col_mem[s] <= '0;
        row_mem[s] <= '0;
      end
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      if (start) begin
        cur_scr <= new_scr;
        if (moves_cursor) begin
          col_mem[cur_scr] <= new_col;
          row_mem[cur_scr] <= new_row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      res_col    <= new_col;
      res_row    <= new_row;
      res_status <= new_status;
      res_read   <= head.op == tcw_pkg::CMD_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) cells[mem_wa] <= mem_wd;
    rd_q <= cells[mem_ra];
  end

  always_comb begin
    result.data   = res_read ? rd_q : 16'h0000;
    result.col    = res_col;
    result.row    = res_row;
    result.off    = tcw_pkg::OFF_W'(32'(res_row) * tcw_pkg::COLUMNS + 32'(res_col));
    result.scr    = cur_scr;
    result.status = res_status;
  end

endmodule

FILE: rtl/text_console_writer_core.sv
// top level of the text console writer: decoder, command queue, sequencer, result register
// depends on tcw_pkg, tcw_front, tcw_queue and tcw_back
//
//   channel   dir  handshake          payload
//   request   in   s_tvalid/s_tready  s_tdata (30 bits used), s_tuser = req_type
//   result    out  m_tvalid/m_tready  m_tdata (45 bits used), m_tuser = status
//
// an ordinary request goes through the sequencer as issue against the cell memory,
//   then load of the result register, which waits for the registered read of the cell memory
// a clear blanks the active screen; a scroll shifts rows up one and blanks the bottom row
// after reset a clearing pass writes blanks over all 2**MEM_AW memory words
//   (8192 words with the default geometry); s_tready stays low until it ends
// up to QUEUE_DEPTH requests wait in the queue while the sequencer or the output stalls

module text_console_writer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code, attribute, cell_position, screen_number, zero pad
  input  logic [2:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // cell_data, cursor_col, cursor_row, cursor_offset,
                                 // active_screen, zero pad
  output logic [0:0]  m_tuser    // status
);

  // decoder to queue
  logic          push;
  logic          q_full;
  tcw_pkg::cmd_t wr_cmd;

  // queue to sequencer
  logic          q_valid;
  logic          pop;
  tcw_pkg::cmd_t head;

  // sequencer to result register
  logic             init_done;
  logic             emit;
  logic             slot_free;
  tcw_pkg::result_t result;
  tcw_pkg::result_t out_res;

  tcw_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .init_done (init_done),
    .push      (push),
    .cmd       (wr_cmd)
  );

  tcw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .full   (q_full),
    .valid  (q_valid),
    .head   (head)
  );

  // the sequencer only starts a command when the result register is free or draining
  assign slot_free = !m_tvalid || m_tready;

  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .slot_free (slot_free),
    .pop       (pop),
    .init_done (init_done),
    .emit      (emit),
    .result    (result)
  );

  // result register: holds one transaction until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_res <= result;
  end

  // pack result fields, lowest field first
  assign m_tdata = {3'b000,
                    3'(out_res.scr),
                    13'(out_res.off),
                    6'(out_res.row),
                    7'(out_res.col),
                    out_res.data};
  assign m_tuser = out_res.status;

endmodule

FILE: rtl/tcw_checker.sv
// port-level checks on the result channel of the text console writer
// depends on tcw_pkg; attached to text_console_writer_core by the bind below

module tcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // a stalled result holds still
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // reported offset matches the reported cursor
  a_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[41:29]) ==
                 32'(m_tdata[28:23]) * tcw_pkg::COLUMNS + 32'(m_tdata[22:16]))
    else $error("cursor offset does not match column and row");

  // cursor and screen stay inside the geometry
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[22:16]) < tcw_pkg::COLUMNS &&
                 32'(m_tdata[28:23]) < tcw_pkg::ROWS &&
                 32'(m_tdata[44:42]) < tcw_pkg::SCREENS)
    else $error("cursor or screen out of range");

  // an ignored request never returns cell data
  a_ignored: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'h0000)
    else $error("ignored request carries cell data");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

FILE: test/text_console_writer_core_tb.sv
// self-checking testbench for text_console_writer_core: streams console requests in,
// predicts every result in a scoreboard class and compares the returned stream field by field
// depends on tcw_pkg and the rtl of text_console_writer_core

module text_console_writer_core_tb;
  import tcw_pkg::*;

  // requests past the last defined code, all of them rejected by the block
  localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
  localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

  localparam int REQUEST_TOTAL  = 1850;
  localparam int IDLE_LIMIT     = 40000;  // reset clearing pass, long hold-off, clear, scroll
  localparam int LONG_HOLD      = 3000;
  localparam int HOLD_AFTER     = 500;    // results seen before the long hold-off starts
  localparam int SETTLE_CYCLES  = 40;

  typedef enum {
    SEQ_TEXT, SEQ_LONG_LINE, SEQ_NEWLINES, SEQ_CELLS, SEQ_SWITCH, SEQ_CLEAR, SEQ_NOISE
  } seq_kind_t;

  typedef enum {RX_ALWAYS, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_mode_t;

  typedef struct {
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic [12:0] cursor_offset;
    logic [2:0]  active_screen;
    logic        status;
  } console_result_t;

  // ---------------------------------------------------------------------------
  // scoreboard: keeps its own copy of every screen and cursor
  // ---------------------------------------------------------------------------
  class console_scoreboard;
    bit [15:0]       cells [SCREENS][CELLS];
    int unsigned     saved_col [SCREENS];
    int unsigned     saved_row [SCREENS];
    int unsigned     shown;
    console_result_t expected_q [$];
    int              errors;

    function new();
      for (int s = 0; s < SCREENS; s++) begin
        blank_screen(s);
        saved_col[s] = 0;
        saved_row[s] = 0;
      end
      shown  = 0;
      errors = 0;
    endfunction

    function void blank_screen(int unsigned scr);
      for (int i = 0; i < CELLS; i++) cells[scr][i] = BLANK_CELL;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted request: update the screens and queue the result it causes
    function void note_request(logic [2:0] req, logic [7:0] ch, logic [7:0] attr,
                               logic [10:0] pos, logic [2:0] tgt);
      console_result_t r;
      int unsigned     scr;
      int unsigned     col;
      int unsigned     row;
      scr = shown;
      col = saved_col[scr];
      row = saved_row[scr];
      r.cell_data = '0;
      r.status    = 1'b0;
      case (req)
        REQ_CURSOR_CHAR: begin
          if (ch == NEWLINE_CHAR) begin
            col = 0;
            row++;
          end else begin
            cells[scr][row * COLUMNS + col] = {attr, ch};
            col++;
          end
          if (col >= COLUMNS) begin
            col = 0;
            row++;
          end
          // past the bottom row: everything moves up one row, bottom row blanked
          if (row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[scr][i] = cells[scr][i + COLUMNS];
            for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) cells[scr][i] = BLANK_CELL;
            row = ROWS - 1;
          end
          saved_col[scr] = col;
          saved_row[scr] = row;
        end
        REQ_POS_CHAR: begin
          if (pos < CELLS) cells[scr][pos] = {attr, ch};
          else r.status = 1'b1;
        end
        REQ_CLEAR: begin
          blank_screen(scr);
          col = 0;
          row = 0;
          saved_col[scr] = 0;
          saved_row[scr] = 0;
        end
        REQ_SWITCH: begin
          if (tgt >= SCREENS || 32'(tgt) == scr) begin
            r.status = 1'b1;
          end else begin
            scr   = 32'(tgt);
            shown = 32'(tgt);
            col   = saved_col[scr];
            row   = saved_row[scr];
          end
        end
        REQ_READ: begin
          if (pos < CELLS) r.cell_data = cells[scr][pos];
          else r.status = 1'b1;
        end
        default: r.status = 1'b1;
      endcase
      r.cursor_col    = 7'(col);
      r.cursor_row    = 6'(row);
      r.cursor_offset = 13'(row * COLUMNS + col);
      r.active_screen = 3'(scr);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // one accepted result against the oldest expectation
    function void check_result(logic [47:0] tdata, logic [0:0] tuser);
      console_result_t r;
      if (expected_q.size() == 0) begin
        $error("result transaction with no request outstanding: tdata %0h", tdata);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      compare_field("cell_data", 32'(r.cell_data), 32'(tdata[15:0]));
      compare_field("cursor_col", 32'(r.cursor_col), 32'(tdata[22:16]));
      compare_field("cursor_row", 32'(r.cursor_row), 32'(tdata[28:23]));
      compare_field("cursor_offset", 32'(r.cursor_offset), 32'(tdata[41:29]));
      compare_field("active_screen", 32'(r.active_screen), 32'(tdata[44:42]));
      compare_field("status", 32'(r.status), 32'(tuser[0]));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, dut
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;

  always #5 clk = ~clk;

  text_console_writer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  console_scoreboard sb = new();

  int results_seen = 0;
  int idle_cycles  = 0;
  int requests_sent = 0;
  int burst_left   = 0;

  // monitor: requests are noted before results are checked at the same edge
  always @(posedge clk) begin
    if (s_tvalid && s_tready)
      sb.note_request(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[26:16], s_tdata[29:27]);
    if (m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser);
      results_seen++;
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
  end

  // watchdog on cycles without any transaction
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("text_console_writer_core_tb: errors");
    $finish;
  end

  // receiver: changes its stall pattern now and then, one long hold-off in the run
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    bit       held;
    mode      = RX_ALWAYS;
    mode_left = 0;
    phase     = 0;
    held      = 1'b0;
    forever begin
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      if (!held && results_seen >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held = 1'b1;
      end
      case (mode)
        RX_ALWAYS:       m_tready <= 1'b1;
        RX_COIN:         m_tready <= 1'($urandom_range(0, 1));
        RX_EVERY_FOURTH: m_tready <= (phase % 4 == 0);
        default:         m_tready <= ($urandom_range(0, 99) < 85);
      endcase
      phase++;
      mode_left--;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // sender tasks
  // ---------------------------------------------------------------------------

  // one request transaction; bursts of random length separated by random gaps
  task automatic push_request(logic [2:0] req, logic [7:0] ch, logic [7:0] attr,
                              logic [10:0] pos, logic [2:0] tgt);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, tgt, pos, attr, ch};
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // sender stops until every result it is owed has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [10:0] pick_position();
    // mostly inside the screen, the rest anywhere in the field range
    if ($urandom_range(0, 4) != 0) return 11'($urandom_range(0, CELLS - 1));
    return 11'($urandom_range(0, 2047));
  endfunction

  task automatic text_char(logic [7:0] ch);
    push_request(REQ_CURSOR_CHAR, ch, 8'($urandom_range(0, 255)),
                 11'($urandom_range(0, 2047)), 3'($urandom_range(0, 7)));
  endtask

  // one sequence of requests; noise sends undefined codes and does not count toward the total
  task automatic run_sequence(seq_kind_t kind);
    int         n;
    logic [7:0] ch;
    logic [2:0] req;
    case (kind)
      SEQ_TEXT: begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          ch = ($urandom_range(0, 15) == 0) ? NEWLINE_CHAR : 8'($urandom_range(0, 255));
          text_char(ch);
        end
        requests_sent += n;
      end
      SEQ_LONG_LINE: begin
        // between 70 and 100 characters, which can wrap the column
        n = $urandom_range(70, 100);
        repeat (n) text_char(8'($urandom_range(0, 255)));
        requests_sent += n;
      end
      SEQ_NEWLINES: begin
        // up to 28 newlines, which can reach the bottom and scroll
        n = $urandom_range(1, 28);
        repeat (n) text_char(NEWLINE_CHAR);
        requests_sent += n;
      end
      SEQ_CELLS: begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          req = $urandom_range(0, 1) ? REQ_POS_CHAR : REQ_READ;
          push_request(req, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       pick_position(), 3'($urandom_range(0, 7)));
        end
        requests_sent += n;
      end
      SEQ_SWITCH: begin
        push_request(REQ_SWITCH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     11'($urandom_range(0, 2047)), 3'($urandom_range(0, 7)));
        requests_sent++;
      end
      SEQ_CLEAR: begin
        push_request(REQ_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     11'($urandom_range(0, 2047)), 3'($urandom_range(0, 7)));
        requests_sent++;
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n)
          push_request(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       11'($urandom_range(0, 2047)), 3'($urandom_range(0, 7)));
      end
    endcase
  endtask

  function automatic seq_kind_t pick_sequence();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return SEQ_TEXT;
    if (roll < 50) return SEQ_LONG_LINE;
    if (roll < 52) return SEQ_NEWLINES;
    if (roll < 77) return SEQ_CELLS;
    if (roll < 88) return SEQ_SWITCH;
    if (roll < 90) return SEQ_CLEAR;
    return SEQ_NOISE;
  endfunction

  // ---------------------------------------------------------------------------
  // main flow
  // ---------------------------------------------------------------------------
  initial begin
    bit paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every request, rejected cases
    push_request(REQ_READ, 8'h00, 8'h00, 11'd0, 3'd0);
    push_request(REQ_CURSOR_CHAR, 8'h00, 8'h00, 11'd0, 3'd0);
    push_request(REQ_CURSOR_CHAR, 8'hFF, 8'hFF, 11'h7FF, 3'd7);
    push_request(REQ_CURSOR_CHAR, NEWLINE_CHAR, 8'hAB, 11'd5, 3'd1);
    push_request(REQ_POS_CHAR, 8'hFF, 8'hFF, 11'd0, 3'd0);
    push_request(REQ_POS_CHAR, 8'h41, 8'h1E, 11'(CELLS - 1), 3'd0);
    push_request(REQ_POS_CHAR, 8'h42, 8'h2F, 11'(CELLS), 3'd0);
    push_request(REQ_POS_CHAR, 8'hFF, 8'hFF, 11'h7FF, 3'd7);
    push_request(REQ_READ, 8'hFF, 8'hFF, 11'(CELLS - 1), 3'd7);
    push_request(REQ_READ, 8'h00, 8'h00, 11'd0, 3'd0);
    push_request(REQ_READ, 8'h00, 8'h00, 11'h7FF, 3'd0);
    push_request(REQ_SWITCH, 8'h00, 8'h00, 11'd0, 3'd0);         // screen already shown
    push_request(REQ_SWITCH, 8'h00, 8'h00, 11'd0, 3'(SCREENS));  // no such screen
    push_request(REQ_SWITCH, 8'hFF, 8'hFF, 11'h7FF, 3'd7);
    push_request(REQ_SWITCH, 8'h00, 8'h00, 11'd0, 3'(SCREENS - 1));
    push_request(REQ_CURSOR_CHAR, 8'h7E, 8'h4C, 11'd0, 3'd0);
    push_request(REQ_READ, 8'h00, 8'h00, 11'd0, 3'd0);
    push_request(REQ_CLEAR, 8'h00, 8'h00, 11'd0, 3'd0);
    push_request(REQ_READ, 8'h00, 8'h00, 11'd0, 3'd0);
    push_request(REQ_SWITCH, 8'h00, 8'h00, 11'd0, 3'd0);
    push_request(REQ_UNUSED_LO, 8'hFF, 8'hFF, 11'h7FF, 3'd7);
    push_request(REQ_UNUSED_MID, 8'h00, 8'h00, 11'd0, 3'd0);
    push_request(REQ_UNUSED_HI, 8'hFF, 8'hFF, 11'h7FF, 3'd7);
    push_request(REQ_CLEAR, 8'hFF, 8'hFF, 11'h7FF, 3'd7);
    requests_sent = 24;
    wait_for_results();

    // random: first a long line and a run of newlines, which can wrap and scroll early
    run_sequence(SEQ_LONG_LINE);
    run_sequence(SEQ_NEWLINES);
    while (requests_sent < REQUEST_TOTAL) begin
      if (!paused && requests_sent >= REQUEST_TOTAL / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      run_sequence(pick_sequence());
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("text_console_writer_core_tb: clean");
    end else begin
      $display("text_console_writer_core_tb: errors");
    end
    $finish;
  end

endmodule
